// ----- design/script_token_scanner_assert.svh -----
// Assertion macros for the token scanner.
// Used by the queue module; needs a clock named clk and a reset named arst_n.
`ifndef SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define STS_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent on one edge implies consequent on the next.
`define STS_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sts_pkg.sv -----
// Types and constants shared by the token scanner modules.
// No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

	typedef struct packed {
		logic [6:0]  kind;
		logic [31:0] offset;
		logic [15:0] length;
		logic [23:0] line;
		logic        line_start;
		logic [20:0] char_value;
	} rec_t;

	typedef struct packed {
		logic [1:0]      count;
		rec_t [2:0]      rec;
	} bundle_t;

	localparam logic [6:0] K_LPAREN    = 7'd0;
	localparam logic [6:0] K_RPAREN    = 7'd1;
	localparam logic [6:0] K_LBRACE    = 7'd2;
	localparam logic [6:0] K_RBRACE    = 7'd3;
	localparam logic [6:0] K_LBRACKET  = 7'd4;
	localparam logic [6:0] K_RBRACKET  = 7'd5;
	localparam logic [6:0] K_PLUS      = 7'd6;
	localparam logic [6:0] K_MINUS     = 7'd7;
	localparam logic [6:0] K_SLASH     = 7'd8;
	localparam logic [6:0] K_STAR      = 7'd9;
	localparam logic [6:0] K_PERCENT   = 7'd11;
	localparam logic [6:0] K_CARET     = 7'd12;
	localparam logic [6:0] K_TILDE     = 7'd13;
	localparam logic [6:0] K_BANG      = 7'd16;
	localparam logic [6:0] K_QUESTION  = 7'd17;
	localparam logic [6:0] K_LT        = 7'd18;
	localparam logic [6:0] K_GT        = 7'd19;
	localparam logic [6:0] K_EQUALS    = 7'd20;
	localparam logic [6:0] K_LTEQ      = 7'd21;
	localparam logic [6:0] K_GTEQ      = 7'd22;
	localparam logic [6:0] K_EQEQ      = 7'd23;
	localparam logic [6:0] K_PLUSEQ    = 7'd24;
	localparam logic [6:0] K_MINUSEQ   = 7'd25;
	localparam logic [6:0] K_STAREQ    = 7'd26;
	localparam logic [6:0] K_SLASHEQ   = 7'd27;
	localparam logic [6:0] K_BANGEQ    = 7'd28;
	localparam logic [6:0] K_SEMICOLON = 7'd34;
	localparam logic [6:0] K_COLON     = 7'd36;
	localparam logic [6:0] K_COMMA     = 7'd37;
	localparam logic [6:0] K_DOT       = 7'd38;
	localparam logic [6:0] K_ARROW     = 7'd39;
	localparam logic [6:0] K_NUMBER    = 7'd40;
	localparam logic [6:0] K_STRING    = 7'd41;
	localparam logic [6:0] K_IDENT     = 7'd42;
	localparam logic [6:0] K_EOF       = 7'd61;
	localparam logic [6:0] K_INVALID   = 7'd62;
	localparam logic [6:0] K_CHAR      = 7'd63;
	localparam logic [6:0] K_WARN      = 7'd64;
	localparam logic [6:0] K_NONE      = 7'd127;

	localparam logic [20:0] CH_NUL    = 21'd0;
	localparam logic [20:0] CH_TAB    = 21'd9;
	localparam logic [20:0] CH_LF     = 21'd10;
	localparam logic [20:0] CH_CR     = 21'd13;
	localparam logic [20:0] CH_ESCAPE = 21'd27;
	localparam logic [20:0] CH_SPACE  = 21'd32;
	localparam logic [20:0] CH_QUOTE  = 21'd34;
	localparam logic [20:0] CH_DOT    = 21'd46;
	localparam logic [20:0] CH_SLASH  = 21'd47;
	localparam logic [20:0] CH_EQUALS = 21'd61;
	localparam logic [20:0] CH_GT     = 21'd62;
	localparam logic [20:0] CH_BSLASH = 21'd92;

	localparam int KW_COUNT = 15;
	localparam logic [63:0] KW_WORD [KW_COUNT] = '{
		"break", "continue", "else", "false", "for", "fun", "if", "init",
		"let", "nil", "print", "return", "true", "var", "while"};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd8, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd4,
		4'd3, 4'd3, 4'd5, 4'd6, 4'd4, 4'd3, 4'd5};
	localparam logic [6:0] KW_KIND [KW_COUNT] = '{
		7'd53, 7'd54, 7'd57, 7'd45, 7'd51, 7'd47, 7'd55, 7'd59,
		7'd49, 7'd46, 7'd60, 7'd50, 7'd44, 7'd48, 7'd52};

	function automatic logic [6:0] single_kind(input logic [20:0] c);
		case (c)
			21'd59:  single_kind = K_SEMICOLON;
			21'd123: single_kind = K_LBRACE;
			21'd125: single_kind = K_RBRACE;
			21'd91:  single_kind = K_LBRACKET;
			21'd93:  single_kind = K_RBRACKET;
			21'd40:  single_kind = K_LPAREN;
			21'd41:  single_kind = K_RPAREN;
			21'd58:  single_kind = K_COLON;
			21'd46:  single_kind = K_DOT;
			21'd44:  single_kind = K_COMMA;
			21'd94:  single_kind = K_CARET;
			21'd126: single_kind = K_TILDE;
			21'd37:  single_kind = K_PERCENT;
			21'd63:  single_kind = K_QUESTION;
			default: single_kind = K_NONE;
		endcase
	endfunction

	function automatic logic [6:0] pair_kind(input logic [20:0] c);
		case (c)
			21'd61:  pair_kind = K_EQUALS;
			21'd33:  pair_kind = K_BANG;
			21'd62:  pair_kind = K_GT;
			21'd60:  pair_kind = K_LT;
			21'd43:  pair_kind = K_PLUS;
			21'd42:  pair_kind = K_STAR;
			21'd45:  pair_kind = K_MINUS;
			21'd47:  pair_kind = K_SLASH;
			default: pair_kind = K_NONE;
		endcase
	endfunction

	function automatic logic [6:0] with_equals(input logic [6:0] k);
		case (k)
			K_EQUALS: with_equals = K_EQEQ;
			K_BANG:   with_equals = K_BANGEQ;
			K_GT:     with_equals = K_GTEQ;
			K_LT:     with_equals = K_LTEQ;
			K_PLUS:   with_equals = K_PLUSEQ;
			K_STAR:   with_equals = K_STAREQ;
			K_MINUS:  with_equals = K_MINUSEQ;
			K_SLASH:  with_equals = K_SLASHEQ;
			default:  with_equals = k;
		endcase
	endfunction

endpackage

// ----- design/sts_front.sv -----
// Front end of the token scanner: accepts code points and classifies them.
// Holds scan state and builds up to three records per code point. Uses sts_pkg.
`timescale 1ns / 1ps

module sts_front #(
	parameter int KEYWORD_CHARS = 8,
	parameter int LINE_BITS     = 24,
	parameter int OFFSET_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              room,
	input  logic [20:0]       code_point,
	output logic              store,
	output sts_pkg::bundle_t  bundle
);

	localparam int KW_IW = $clog2(KEYWORD_CHARS);

	typedef enum logic [3:0] {
		M_IDLE, M_NUM, M_NUMDOT, M_FRAC, M_IDENT, M_STR, M_ESC, M_OPER, M_COMMENT
	} mode_t;

	mode_t                  mode_q, mode_n;
	logic [6:0]             held_q, held_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, start_q, start_n;
	logic [15:0]            bytes_q, bytes_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic                   als_q, als_n;
	logic [7:0]             kw_q [KEYWORD_CHARS];
	logic [7:0]             kw_n [KEYWORD_CHARS];
	logic [7:0]             kw_we;
	logic [2:0]             sz;
	logic [1:0]             cnt;
	sts_pkg::rec_t [2:0]    recs;
	logic                   do_idle;
	logic                   is_dig, is_head, match;
	logic [6:0]             ikind, k1, k2;
	logic [16:0]            idx;
	logic [20:0]            c;
	logic [20:0]            esc_v;
	logic                   esc_ok;

	function automatic sts_pkg::rec_t mk(
		input logic [6:0]             kind,
		input logic [OFFSET_BITS-1:0] off,
		input logic [16:0]            len,
		input logic [LINE_BITS-1:0]   line,
		input logic                   ls,
		input logic [20:0]            ch
	);
		logic [63:0] ow;
		logic [63:0] lw;
		ow = 64'(off);
		lw = 64'(line);
		mk.kind       = kind;
		mk.offset     = ow[31:0];
		mk.length     = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
		mk.line       = (lw > 64'hFFFFFF) ? 24'hFFFFFF : lw[23:0];
		mk.line_start = ls;
		mk.char_value = ch;
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] b, input logic [2:0] n);
		logic [16:0] t;
		t = 17'(b) + 17'(n);
		sat_add = t[16] ? 16'hFFFF : t[15:0];
	endfunction

	assign c       = code_point;
	assign is_dig  = (c >= 21'd48) && (c <= 21'd57);
	assign is_head = ((c >= 21'd97) && (c <= 21'd122)) || ((c >= 21'd65) && (c <= 21'd90))
		|| (c == 21'd95) || (c >= 21'h80);

	always_comb begin
		if (c < 21'h80)
			sz = 3'd1;
		else if (c < 21'h800)
			sz = 3'd2;
		else if (c < 21'h10000)
			sz = 3'd3;
		else
			sz = 3'd4;
	end

	always_comb begin
		ikind = sts_pkg::K_IDENT;
		if (bytes_q <= 16'(KEYWORD_CHARS)) begin
			for (int e = sts_pkg::KW_COUNT - 1; e >= 0; e--) begin
				match = (16'(sts_pkg::KW_LEN[e]) == bytes_q);
				for (int i = 0; i < 8; i++) begin
					if (i < int'(sts_pkg::KW_LEN[e]) &&
						kw_q[KW_IW'(i)] !=
						sts_pkg::KW_WORD[e][8*(int'(sts_pkg::KW_LEN[e])-1-i) +: 8])
						match = 1'b0;
				end
				if (match)
					ikind = sts_pkg::KW_KIND[e];
			end
		end else begin
			match = 1'b0;
		end
	end

	always_comb begin
		esc_ok = 1'b1;
		case (c)
			sts_pkg::CH_BSLASH: esc_v = sts_pkg::CH_BSLASH;
			21'd110:            esc_v = sts_pkg::CH_LF;
			21'd114:            esc_v = sts_pkg::CH_CR;
			21'd116:            esc_v = sts_pkg::CH_TAB;
			21'd101:            esc_v = sts_pkg::CH_ESCAPE;
			sts_pkg::CH_QUOTE:  esc_v = sts_pkg::CH_QUOTE;
			default: begin
				esc_v  = '0;
				esc_ok = 1'b0;
			end
		endcase
	end

	assign k1 = sts_pkg::pair_kind(c);
	assign k2 = sts_pkg::single_kind(c);

	always_comb begin
		mode_n  = mode_q;
		held_n  = held_q;
		start_n = start_q;
		bytes_n = bytes_q;
		line_n  = line_q;
		als_n   = als_q;
		kw_we   = '0;
		for (int i = 0; i < KEYWORD_CHARS; i++)
			kw_n[i] = kw_q[i];
		cnt     = 2'd0;
		recs    = '0;
		do_idle = 1'b0;
		idx     = '0;

		case (mode_q)
			M_NUM, M_FRAC: begin
				if (is_dig)
					bytes_n = sat_add(bytes_n, 3'd1);
				else if (c == sts_pkg::CH_DOT && mode_q == M_NUM)
					mode_n = M_NUMDOT;
				else begin
					recs[cnt] = mk(sts_pkg::K_NUMBER, start_n, 17'(bytes_n), line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					do_idle = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (is_dig) begin
					bytes_n = sat_add(bytes_n, 3'd2);
					mode_n  = M_FRAC;
				end else begin
					recs[cnt] = mk(sts_pkg::K_NUMBER, start_n, 17'(bytes_n), line_n, als_n, '0);
					cnt = cnt + 2'd1;
					recs[cnt] = mk(sts_pkg::K_DOT, pos_q - OFFSET_BITS'(1), 17'd1, line_n,
						1'b0, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					do_idle = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_head || is_dig) begin
					for (int k = 0; k < 4; k++) begin
						idx = 17'(bytes_n) + 17'(k);
						if (k < int'(sz) && idx < 17'(KEYWORD_CHARS)) begin
							kw_n[idx[KW_IW-1:0]] = (k == 0 && c < 21'h80) ? c[7:0] : 8'd0;
							kw_we[k] = 1'b1;
						end
					end
					bytes_n = sat_add(bytes_n, sz);
				end else begin
					recs[cnt] = mk(ikind, start_n, 17'(bytes_n), line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					do_idle = 1'b1;
				end
			end
			M_STR, M_ESC: begin
				if (c == sts_pkg::CH_NUL) begin
					recs[cnt] = mk(sts_pkg::K_INVALID, start_n, 17'd1, line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					mode_n = M_IDLE;
					recs[cnt] = mk(sts_pkg::K_EOF, pos_q, 17'd0, line_n, als_n, '0);
					cnt = cnt + 2'd1;
				end else begin
					if (c == sts_pkg::CH_LF && line_n != '1)
						line_n = line_n + LINE_BITS'(1);
					bytes_n = sat_add(bytes_n, sz);
					if (mode_q == M_ESC) begin
						mode_n = M_STR;
						if (esc_ok)
							recs[cnt] = mk(sts_pkg::K_CHAR, pos_q - OFFSET_BITS'(1), 17'd2,
								line_n, 1'b0, esc_v);
						else
							recs[cnt] = mk(sts_pkg::K_WARN, pos_q - OFFSET_BITS'(1), 17'd1,
								line_n, 1'b0, '0);
						cnt = cnt + 2'd1;
					end else if (c == sts_pkg::CH_QUOTE) begin
						recs[cnt] = mk(sts_pkg::K_STRING, start_n, 17'(bytes_n), line_n,
							als_n, '0);
						cnt = cnt + 2'd1;
						als_n = 1'b0;
						mode_n = M_IDLE;
					end else if (c == sts_pkg::CH_BSLASH) begin
						mode_n = M_ESC;
					end else begin
						recs[cnt] = mk(sts_pkg::K_CHAR, pos_q, 17'(sz), line_n, 1'b0, c);
						cnt = cnt + 2'd1;
					end
				end
			end
			M_OPER: begin
				if (held_q == sts_pkg::K_SLASH && c == sts_pkg::CH_SLASH) begin
					mode_n = M_COMMENT;
				end else if (c == sts_pkg::CH_EQUALS) begin
					bytes_n = sat_add(bytes_n, 3'd1);
					recs[cnt] = mk(sts_pkg::with_equals(held_q), start_n, 17'(bytes_n), line_n,
						als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					mode_n = M_IDLE;
				end else if (held_q == sts_pkg::K_MINUS && c == sts_pkg::CH_GT) begin
					bytes_n = sat_add(bytes_n, 3'd1);
					recs[cnt] = mk(sts_pkg::K_ARROW, start_n, 17'(bytes_n), line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					mode_n = M_IDLE;
				end else begin
					recs[cnt] = mk(held_q, start_n, 17'(bytes_n), line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
					do_idle = 1'b1;
				end
			end
			M_COMMENT: begin
				if (c == sts_pkg::CH_NUL || c == sts_pkg::CH_LF)
					do_idle = 1'b1;
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		if (do_idle) begin
			mode_n = M_IDLE;
			if (c == sts_pkg::CH_NUL) begin
				recs[cnt] = mk(sts_pkg::K_EOF, pos_q, 17'd0, line_n, als_n, '0);
				cnt = cnt + 2'd1;
				als_n = 1'b0;
			end else if (c == sts_pkg::CH_SPACE || c == sts_pkg::CH_TAB ||
				c == sts_pkg::CH_CR) begin
				mode_n = M_IDLE;
			end else if (c == sts_pkg::CH_LF) begin
				if (line_n != '1)
					line_n = line_n + LINE_BITS'(1);
				als_n = 1'b1;
			end else begin
				start_n = pos_q;
				bytes_n = '0;
				if (is_dig) begin
					mode_n  = M_NUM;
					bytes_n = 16'd1;
				end else if (is_head) begin
					mode_n = M_IDENT;
					for (int k = 0; k < 4; k++) begin
						if (k < int'(sz)) begin
							kw_n[KW_IW'(k)] = (k == 0 && c < 21'h80) ? c[7:0] : 8'd0;
							kw_we[4+k] = 1'b1;
						end
					end
					bytes_n = 16'(sz);
				end else if (c == sts_pkg::CH_QUOTE) begin
					mode_n  = M_STR;
					bytes_n = 16'd1;
				end else if (k1 != sts_pkg::K_NONE) begin
					mode_n  = M_OPER;
					held_n  = k1;
					bytes_n = 16'd1;
				end else begin
					recs[cnt] = mk((k2 != sts_pkg::K_NONE) ? k2 : sts_pkg::K_INVALID, pos_q,
						17'd1, line_n, als_n, '0);
					cnt = cnt + 2'd1;
					als_n = 1'b0;
				end
			end
		end

		pos_n = (c != sts_pkg::CH_NUL) ? pos_q + OFFSET_BITS'(sz) : pos_q;
	end

	assign store        = take && room && (cnt != 2'd0);
	assign bundle.count = cnt;
	assign bundle.rec   = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			held_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			bytes_q <= '0;
			line_q  <= LINE_BITS'(1);
			als_q   <= 1'b1;
		end else if (take && room) begin
			mode_q  <= mode_n;
			held_q  <= held_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			bytes_q <= bytes_n;
			line_q  <= line_n;
			als_q   <= als_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && room && (kw_we != '0)) begin
			for (int i = 0; i < KEYWORD_CHARS; i++)
				kw_q[i] <= kw_n[i];
		end
	end

endmodule

// ----- design/sts_queue.sv -----
// Back end of the token scanner: queue of record bundles and serialiser.
// Hands out one record per pop. Uses sts_pkg and the assertion header.
`timescale 1ns / 1ps
`include "script_token_scanner_assert.svh"

module sts_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             store,
	input  sts_pkg::bundle_t bundle,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output sts_pkg::rec_t    head,
	output logic             last
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	sts_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      occ_q;
	logic [1:0]       idx_q;
	sts_pkg::bundle_t top_b;
	logic             done;

	assign top_b = mem_q[rd_q];
	assign full  = (occ_q == (PW+1)'(DEPTH));
	assign empty = (occ_q == '0);
	assign head  = top_b.rec[idx_q];
	assign last  = (idx_q == top_b.count - 2'd1);
	assign done  = pop && !empty && last;

	always_ff @(posedge clk) begin
		if (store && !full)
			mem_q[wr_q] <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
			idx_q <= '0;
		end else begin
			if (store && !full)
				wr_q <= wr_q + PW'(1);
			if (done) begin
				rd_q  <= rd_q + PW'(1);
				idx_q <= '0;
			end else if (pop && !empty) begin
				idx_q <= idx_q + 2'd1;
			end
			occ_q <= occ_q + (PW+1)'(store && !full) - (PW+1)'(done);
		end
	end

	`STS_ALWAYS(a_occ_bound, occ_q <= (PW+1)'(DEPTH), "queue occupancy beyond depth")
	`STS_ALWAYS(a_store_nonempty, !store || bundle.count != 2'd0, "empty bundle stored")
	`STS_ALWAYS(a_idx_range, empty || idx_q < top_b.count, "record index past bundle")
	`STS_NEXT(a_drain, done && occ_q == (PW+1)'(1) && !store, empty, "queue not empty after drain")

endmodule

// ----- design/script_token_scanner.sv -----
// Top level of the token scanner: front classifier feeding a bundle queue.
// Depends on sts_pkg, sts_front and sts_queue.
//
// channel  | handshake          | payload
// input    | push / full        | code_point
// result   | pop / empty        | token_kind .. char_value, last
//
// One code point is taken per cycle while the four-bundle queue has room.
// Each code point yields zero to three records; the queue drains one record per cycle while pop is high.
// Sustained rate is one code point per cycle when results average at most one each.
// Reset clears scan state and the queue; full and empty follow the queue occupancy.
`timescale 1ns / 1ps

module script_token_scanner #(
	parameter int KEYWORD_CHARS = 8,
	parameter int LINE_BITS     = 24,
	parameter int OFFSET_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [20:0] code_point,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  token_kind,
	output logic [31:0] token_offset,
	output logic [15:0] token_length,
	output logic [23:0] token_line,
	output logic        line_start,
	output logic [20:0] char_value,
	output logic        last
);

	logic             store;
	sts_pkg::bundle_t bundle;
	sts_pkg::rec_t    head;

	sts_front #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.LINE_BITS(LINE_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(push),
		.room(!full),
		.code_point(code_point),
		.store(store),
		.bundle(bundle)
	);

	sts_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.store(store),
		.bundle(bundle),
		.full(full),
		.empty(empty),
		.pop(pop),
		.head(head),
		.last(last)
	);

	assign token_kind   = head.kind;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign line_start   = head.line_start;
	assign char_value   = head.char_value;

endmodule
